### rtl/key_chord_matcher_top_macros.svh
// Assertion helpers for the key chord matcher RTL.
`ifndef KEY_CHORD_MATCHER_TOP_MACROS_SVH
`define KEY_CHORD_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KCM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KCM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kcm_pkg.sv
// ----------------------------------------------------------------------------
// kcm_pkg
// Shared types and constants of the key chord matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package kcm_pkg;

    localparam int KEYBOARDS_DEF = 4;
    localparam int KEYS_DEF      = 256;
    localparam int BUTTONS_DEF   = 16;
    localparam int COMBOS_DEF    = 4;
    localparam int MODS_DEF      = 3;

    localparam int CFG_W = 3;
    localparam int OPC_W = 2;
    localparam int KB_W  = 2;
    localparam int KEY_W = 8;
    localparam int BTN_W = 4;
    localparam int CS_W  = 2;
    localparam int KS_W  = 2;
    localparam int BASE_W = KB_W + KEY_W;

    localparam logic [OPC_W-1:0] OPC_SAMPLE = 2'd0;
    localparam logic [OPC_W-1:0] OPC_RULE   = 2'd1;
    localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd2;
    localparam logic [OPC_W-1:0] OPC_CLEAR  = 2'd3;

    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SAMPLE,
        CMD_RULE,
        CMD_QUERY,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [KB_W-1:0]   kb;
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic [BTN_W-1:0]  btn;
        logic [CS_W-1:0]   cs;
        logic [KS_W-1:0]   ks;
        logic              ev;
        logic              oneshot;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/kcm_front.sv
// ----------------------------------------------------------------------------
// kcm_front
// Accepts input beats, range-checks rule writes and queries, and pushes
// a decoded command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_front
    import kcm_pkg::*;
#(
    parameter int BUTTONS           = BUTTONS_DEF,
    parameter int COMBOS_PER_BUTTON = COMBOS_DEF,
    parameter int MODS_PER_COMBO    = MODS_DEF
) (
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [OPC_W-1:0]  i_opcode,
    input  wire logic [KB_W-1:0]   i_keyboard,
    input  wire logic [KEY_W-1:0]  i_key_index,
    input  wire logic              i_pressed,
    input  wire logic [BTN_W-1:0]  i_button_id,
    input  wire logic [CS_W-1:0]   i_combo_slot,
    input  wire logic [KS_W-1:0]   i_key_slot,
    input  wire logic              i_entry_valid,
    input  wire logic              i_oneshot,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_q_cmd
);

    logic btn_ok;
    logic rule_ok;

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        btn_ok  = 32'(i_button_id) < BUTTONS;
        rule_ok = btn_ok && (32'(i_combo_slot) < COMBOS_PER_BUTTON)
                  && (32'(i_key_slot) <= MODS_PER_COMBO);
        o_q_cmd.kb      = i_keyboard;
        o_q_cmd.key     = i_key_index;
        o_q_cmd.pressed = i_pressed;
        o_q_cmd.btn     = i_button_id;
        o_q_cmd.cs      = i_combo_slot;
        o_q_cmd.ks      = i_key_slot;
        o_q_cmd.ev      = i_entry_valid;
        o_q_cmd.oneshot = i_oneshot;
        case (i_opcode)
            OPC_SAMPLE: o_q_cmd.kind = CMD_SAMPLE;
            OPC_RULE:   o_q_cmd.kind = rule_ok ? CMD_RULE : CMD_NOP;
            OPC_QUERY:  o_q_cmd.kind = btn_ok ? CMD_QUERY : CMD_NOP;
            OPC_CLEAR:  o_q_cmd.kind = CMD_CLEAR;
            default:    o_q_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

### rtl/kcm_fifo.sv
// ----------------------------------------------------------------------------
// kcm_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module kcm_fifo
    import kcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(QDEPTH);

    t_cmd                 r_mem [QDEPTH];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [PTR_W:0]       r_cnt;

    assign o_full  = r_cnt == (PTR_W+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/kcm_back.sv
// ----------------------------------------------------------------------------
// kcm_back
// Executes commands: key state updates, rule table writes, clearing
// sweeps and the sequential chord search of a query.
// ----------------------------------------------------------------------------
`default_nettype none
`include "key_chord_matcher_top_macros.svh"

module kcm_back
    import kcm_pkg::*;
#(
    parameter int KEYBOARDS         = KEYBOARDS_DEF,
    parameter int KEYS_PER_KEYBOARD = KEYS_DEF,
    parameter int BUTTONS           = BUTTONS_DEF,
    parameter int COMBOS_PER_BUTTON = COMBOS_DEF,
    parameter int MODS_PER_COMBO    = MODS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_q_empty,
    input  wire t_cmd             i_q_head,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    output logic                  o_active,
    input  wire logic             i_out_stall
);

    localparam int KS_DEPTH = KEYBOARDS * KEYS_PER_KEYBOARD;
    localparam int KA_W     = $clog2(KS_DEPTH);
    localparam int KI_W     = $clog2(KEYS_PER_KEYBOARD);
    localparam int KB_IW    = (KEYBOARDS > 1) ? $clog2(KEYBOARDS) : 1;
    localparam int CNT_W    = $clog2(KEYBOARDS + 1);
    localparam int NCOMBO   = BUTTONS * COMBOS_PER_BUTTON;
    localparam int CI_W     = (NCOMBO > 1) ? $clog2(NCOMBO) : 1;
    localparam int CC_W     = (COMBOS_PER_BUTTON > 1) ? $clog2(COMBOS_PER_BUTTON) : 1;
    localparam int MODS_D   = (MODS_PER_COMBO > 0) ? MODS_PER_COMBO : 1;
    localparam int MI_W     = (MODS_D > 1) ? $clog2(MODS_D) : 1;
    localparam int NMOD     = NCOMBO * MODS_D;
    localparam int MA_W     = (NMOD > 1) ? $clog2(NMOD) : 1;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_SWEEP  = 16'h0002,
        S_SMP_RD = 16'h0004,
        S_SMP_WR = 16'h0008,
        S_QB_RD  = 16'h0010,
        S_QB_CHK = 16'h0020,
        S_QB_KS  = 16'h0040,
        S_QO_RD  = 16'h0080,
        S_QO_CHK = 16'h0100,
        S_QO_KS  = 16'h0200,
        S_SB_RD  = 16'h0400,
        S_SB_CHK = 16'h0800,
        S_SM_RD  = 16'h1000,
        S_SM_CHK = 16'h2000,
        S_SM_KS  = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    // storage
    logic [1:0]        ks_mem   [KS_DEPTH];
    logic [BASE_W-1:0] base_mem [NCOMBO];
    logic [KEY_W-1:0]  mod_mem  [NMOD];
    logic [NCOMBO-1:0] r_bvalid;
    logic [NMOD-1:0]   r_mvalid;
    logic [1:0]        r_ks_rd;
    logic [BASE_W-1:0] r_b_rd;
    logic              r_bv_rd;
    logic [KEY_W-1:0]  r_m_rd;
    logic              r_mv_rd;

    // control and working registers
    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [CC_W-1:0]    r_c, n_c;
    logic [CI_W-1:0]    r_sc, n_sc;
    logic [MI_W-1:0]    r_m, n_m;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [KEY_W-1:0]   r_own_key [MODS_D];
    logic [MODS_D-1:0]  r_own_v, n_own_v;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [KEYBOARDS-1:0] r_dirty, n_dirty;
    logic [KB_IW-1:0]   r_kb_sw, n_kb_sw;
    logic [KI_W-1:0]    r_key_sw, n_key_sw;
    logic               r_act, n_act;
    logic               r_out_valid, n_out_valid;
    logic               r_out_active, n_out_active;

    // memory ports
    logic [KA_W-1:0]   ks_ra, ks_wa;
    logic              ks_we;
    logic [1:0]        ks_wd;
    logic [CI_W-1:0]   b_ra, b_wa;
    logic              b_we;
    logic [MA_W-1:0]   m_ra, m_wa;
    logic              m_we;
    logic              own_we;

    logic [CI_W-1:0]   cur_combo;
    logic [CI_W-1:0]   rule_combo;
    logic              in_own;
    logic [KB_IW-1:0]  sw_pick;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_active    = r_out_active;

    always_comb begin
        cur_combo  = CI_W'(int'(r_cmd.btn) * COMBOS_PER_BUTTON + int'(r_c));
        rule_combo = CI_W'(int'(i_q_head.btn) * COMBOS_PER_BUTTON + int'(i_q_head.cs));
        in_own = 1'b0;
        for (int i = 0; i < MODS_D; i++) begin
            if (r_own_v[i] && r_own_key[i] == r_m_rd) in_own = 1'b1;
        end
        sw_pick = '0;
        for (int k = KEYBOARDS - 1; k >= 0; k--) begin
            if (r_dirty[k]) sw_pick = KB_IW'(k);
        end
    end

    always_comb begin
        int cfg_n;
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_c          = r_c;
        n_sc         = r_sc;
        n_m          = r_m;
        n_base       = r_base;
        n_own_v      = r_own_v;
        n_count      = r_count;
        n_dirty      = r_dirty;
        n_kb_sw      = r_kb_sw;
        n_key_sw     = r_key_sw;
        n_act        = r_act;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_active = r_out_active;
        o_q_pop = 1'b0;
        ks_ra   = '0;
        ks_wa   = '0;
        ks_we   = 1'b0;
        ks_wd   = '0;
        b_ra    = '0;
        b_wa    = rule_combo;
        b_we    = 1'b0;
        m_ra    = '0;
        m_wa    = MA_W'(int'(rule_combo) * MODS_D + int'(i_q_head.ks) - 1);
        m_we    = 1'b0;
        own_we  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (r_dirty != '0) begin
                    n_kb_sw  = sw_pick;
                    n_key_sw = '0;
                    n_state  = S_SWEEP;
                end else if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_act   = 1'b0;
                    case (i_q_head.kind)
                        CMD_SAMPLE: n_state = S_SMP_RD;
                        CMD_RULE: begin
                            b_we    = i_q_head.ks == '0;
                            m_we    = i_q_head.ks != '0;
                            n_state = S_DONE;
                        end
                        CMD_QUERY: begin
                            n_c     = '0;
                            n_state = S_QB_RD;
                        end
                        CMD_CLEAR: begin
                            n_dirty = '1;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SWEEP: begin
                ks_we = 1'b1;
                ks_wa = KA_W'(int'(r_kb_sw) * KEYS_PER_KEYBOARD + int'(r_key_sw));
                if (r_key_sw == KI_W'(KEYS_PER_KEYBOARD - 1)) begin
                    n_dirty[r_kb_sw] = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_key_sw = r_key_sw + 1'b1;
                end
            end
            S_SMP_RD: begin
                ks_ra = KA_W'(int'(r_cmd.kb) * KEYS_PER_KEYBOARD + int'(r_cmd.key));
                if (32'(r_cmd.kb) < 32'(r_count) && 32'(r_cmd.key) < KEYS_PER_KEYBOARD)
                    n_state = S_SMP_WR;
                else
                    n_state = S_DONE;
            end
            S_SMP_WR: begin
                ks_we   = 1'b1;
                ks_wa   = KA_W'(int'(r_cmd.kb) * KEYS_PER_KEYBOARD + int'(r_cmd.key));
                ks_wd   = {r_ks_rd[0] ^ r_cmd.pressed, r_cmd.pressed};
                n_state = S_DONE;
            end
            S_QB_RD: begin
                b_ra    = cur_combo;
                n_state = S_QB_CHK;
            end
            S_QB_CHK: begin
                ks_ra  = KA_W'(int'(r_b_rd[BASE_W-1:KEY_W]) * KEYS_PER_KEYBOARD
                               + int'(r_b_rd[KEY_W-1:0]));
                n_base = r_b_rd;
                if (r_bv_rd && 32'(r_b_rd[BASE_W-1:KEY_W]) < 32'(r_count)) begin
                    n_state = S_QB_KS;
                end else if (r_c == CC_W'(COMBOS_PER_BUTTON - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_state = S_QB_RD;
                end
            end
            S_QB_KS: begin
                if (32'(r_base[KEY_W-1:0]) >= KEYS_PER_KEYBOARD || !r_ks_rd[0]
                    || (r_cmd.oneshot && r_ks_rd != 2'b11)) begin
                    if (r_c == CC_W'(COMBOS_PER_BUTTON - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = S_QB_RD;
                    end
                end else begin
                    n_m     = '0;
                    n_state = S_QO_RD;
                end
            end
            S_QO_RD: begin
                m_ra    = MA_W'(int'(cur_combo) * MODS_D + int'(r_m));
                n_state = S_QO_CHK;
            end
            S_QO_CHK: begin
                ks_ra  = KA_W'(int'(r_base[BASE_W-1:KEY_W]) * KEYS_PER_KEYBOARD
                               + int'(r_m_rd));
                own_we = 1'b1;
                n_own_v[r_m] = r_mv_rd;
                if (r_mv_rd && 32'(r_m_rd) >= KEYS_PER_KEYBOARD) begin
                    // modifier can never be held: drop this combination
                    if (r_c == CC_W'(COMBOS_PER_BUTTON - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = S_QB_RD;
                    end
                end else if (r_mv_rd) begin
                    n_state = S_QO_KS;
                end else if (r_m == MI_W'(MODS_D - 1)) begin
                    n_sc    = '0;
                    n_state = S_SB_RD;
                end else begin
                    n_m     = r_m + 1'b1;
                    n_state = S_QO_RD;
                end
            end
            S_QO_KS: begin
                if (!r_ks_rd[0]) begin
                    if (r_c == CC_W'(COMBOS_PER_BUTTON - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = S_QB_RD;
                    end
                end else if (r_m == MI_W'(MODS_D - 1)) begin
                    n_sc    = '0;
                    n_state = S_SB_RD;
                end else begin
                    n_m     = r_m + 1'b1;
                    n_state = S_QO_RD;
                end
            end
            S_SB_RD: begin
                b_ra    = r_sc;
                n_state = S_SB_CHK;
            end
            S_SB_CHK: begin
                if (r_bv_rd && r_b_rd == r_base) begin
                    n_m     = '0;
                    n_state = S_SM_RD;
                end else if (r_sc == CI_W'(NCOMBO - 1)) begin
                    n_act   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_sc    = r_sc + 1'b1;
                    n_state = S_SB_RD;
                end
            end
            S_SM_RD: begin
                m_ra    = MA_W'(int'(r_sc) * MODS_D + int'(r_m));
                n_state = S_SM_CHK;
            end
            S_SM_CHK: begin
                ks_ra = KA_W'(int'(r_base[BASE_W-1:KEY_W]) * KEYS_PER_KEYBOARD
                              + int'(r_m_rd));
                if (r_mv_rd && !in_own && 32'(r_m_rd) < KEYS_PER_KEYBOARD) begin
                    n_state = S_SM_KS;
                end else if (r_m != MI_W'(MODS_D - 1)) begin
                    n_m     = r_m + 1'b1;
                    n_state = S_SM_RD;
                end else if (r_sc == CI_W'(NCOMBO - 1)) begin
                    n_act   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_sc    = r_sc + 1'b1;
                    n_state = S_SB_RD;
                end
            end
            S_SM_KS: begin
                if (r_ks_rd[0]) begin
                    // a foreign modifier of this base is held
                    if (r_c == CC_W'(COMBOS_PER_BUTTON - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = S_QB_RD;
                    end
                end else if (r_m != MI_W'(MODS_D - 1)) begin
                    n_m     = r_m + 1'b1;
                    n_state = S_SM_RD;
                end else if (r_sc == CI_W'(NCOMBO - 1)) begin
                    n_act   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_sc    = r_sc + 1'b1;
                    n_state = S_SB_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_active = r_act;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // keyboard count register; newly counted keyboards get cleared
        if (i_cfg_valid) begin
            cfg_n = int'(i_cfg_data);
            if (cfg_n == 0) cfg_n = 1;
            if (cfg_n > KEYBOARDS) cfg_n = KEYBOARDS;
            for (int k = 0; k < KEYBOARDS; k++) begin
                if (k >= int'(r_count) && k < cfg_n) n_dirty[k] = 1'b1;
            end
            n_count = CNT_W'(cfg_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ks_we) ks_mem[ks_wa] <= ks_wd;
        r_ks_rd <= ks_mem[ks_ra];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) base_mem[b_wa] <= {i_q_head.kb, i_q_head.key};
        r_b_rd <= base_mem[b_ra];
    end

    always_ff @(posedge i_clk) begin
        if (m_we) mod_mem[m_wa] <= i_q_head.key;
        r_m_rd <= mod_mem[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= '0;
            r_mvalid <= '0;
        end else begin
            if (b_we) r_bvalid[b_wa] <= i_q_head.ev;
            if (m_we) r_mvalid[m_wa] <= i_q_head.ev;
        end
        r_bv_rd <= r_bvalid[b_ra];
        r_mv_rd <= r_mvalid[m_ra];
    end

    always_ff @(posedge i_clk) begin
        if (own_we) r_own_key[r_m] <= r_m_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CNT_W'(1);
            r_dirty     <= '1;
            r_out_valid <= 1'b0;
            r_own_v     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dirty     <= n_dirty;
            r_out_valid <= n_out_valid;
            r_own_v     <= n_own_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_c          <= n_c;
        r_sc         <= n_sc;
        r_m          <= n_m;
        r_base       <= n_base;
        r_kb_sw      <= n_kb_sw;
        r_key_sw     <= n_key_sw;
        r_act        <= n_act;
        r_out_active <= n_out_active;
    end

    `KCM_ASSERT_IMP(a_pop_clean, o_q_pop, r_dirty == '0, "command taken before clear sweep done")
    `KCM_ASSERT_IMP(a_sweep_dirty, r_state == S_SWEEP, r_dirty != '0, "sweep with nothing to clear")
    `KCM_ASSERT_IMP(a_count_range, 1'b1, r_count >= CNT_W'(1) && r_count <= CNT_W'(KEYBOARDS), "keyboard count out of range")
    `KCM_ASSERT_NXT(a_active_query, o_q_pop && i_q_head.kind != CMD_QUERY, !r_act, "active set on non-query")

endmodule

`default_nettype wire

### rtl/key_chord_matcher_top.sv
// Results: every beat gives one result beat; a query scans the rule tables sequentially.
// Throughput: one beat executes at a time, two more wait in the queue; after a clear
//   a sweep over the key states of all KEYBOARDS keyboards runs before the next beat.
// Reset (synchronous, active low) runs the same sweep; rule tables start empty.
// ----------------------------------------------------------------------------
// key_chord_matcher_top
// Key state tracker with button chord matching.
// ----------------------------------------------------------------------------
`default_nettype none

module key_chord_matcher_top
    import kcm_pkg::*;
#(
    parameter int KEYBOARDS         = KEYBOARDS_DEF,
    parameter int KEYS_PER_KEYBOARD = KEYS_DEF,
    parameter int BUTTONS           = BUTTONS_DEF,
    parameter int COMBOS_PER_BUTTON = COMBOS_DEF,
    parameter int MODS_PER_COMBO    = MODS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [OPC_W-1:0] i_opcode,
    input  wire logic [KB_W-1:0]  i_keyboard,
    input  wire logic [KEY_W-1:0] i_key_index,
    input  wire logic             i_pressed,
    input  wire logic [BTN_W-1:0] i_button_id,
    input  wire logic [CS_W-1:0]  i_combo_slot,
    input  wire logic [KS_W-1:0]  i_key_slot,
    input  wire logic             i_entry_valid,
    input  wire logic             i_oneshot,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_active
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_head;

    kcm_front #(
        .BUTTONS           (BUTTONS),
        .COMBOS_PER_BUTTON (COMBOS_PER_BUTTON),
        .MODS_PER_COMBO    (MODS_PER_COMBO)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_keyboard    (i_keyboard),
        .i_key_index   (i_key_index),
        .i_pressed     (i_pressed),
        .i_button_id   (i_button_id),
        .i_combo_slot  (i_combo_slot),
        .i_key_slot    (i_key_slot),
        .i_entry_valid (i_entry_valid),
        .i_oneshot     (i_oneshot),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in)
    );

    kcm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    kcm_back #(
        .KEYBOARDS         (KEYBOARDS),
        .KEYS_PER_KEYBOARD (KEYS_PER_KEYBOARD),
        .BUTTONS           (BUTTONS),
        .COMBOS_PER_BUTTON (COMBOS_PER_BUTTON),
        .MODS_PER_COMBO    (MODS_PER_COMBO)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_active    (o_active),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

### verif/kcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcm_checker
// Watches the command, config and result channels of the key chord matcher,
// keeps its own key and rule tables, and compares the active flag of every result beat.
// ----------------------------------------------------------------------------

module kcm_checker
    import kcm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [OPC_W-1:0] i_opcode,
    input  logic [KB_W-1:0]  i_keyboard,
    input  logic [KEY_W-1:0] i_key_index,
    input  logic             i_pressed,
    input  logic [BTN_W-1:0] i_button_id,
    input  logic [CS_W-1:0]  i_combo_slot,
    input  logic [KS_W-1:0]  i_key_slot,
    input  logic             i_entry_valid,
    input  logic             i_oneshot,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic             i_active,
    output int               o_errors,
    output int               o_pending
);

    logic [1:0]  key_st [KEYBOARDS_DEF][KEYS_DEF];
    logic        base_ok [BUTTONS_DEF][COMBOS_DEF];
    logic [9:0]  base_key [BUTTONS_DEF][COMBOS_DEF];
    logic        mod_ok [BUTTONS_DEF][COMBOS_DEF][1:MODS_DEF];
    logic [7:0]  mod_key [BUTTONS_DEF][COMBOS_DEF][1:MODS_DEF];
    int          kb_count;
    logic        expected_active[$];

    assign o_pending = expected_active.size();

    function automatic logic combo_uses(input int b, input int c, input logic [7:0] k);
        for (int m = 1; m <= MODS_DEF; m++)
            if (mod_ok[b][c][m] && mod_key[b][c][m] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic chord_on(input int b, input int c, input logic shot);
        int kb;
        logic [7:0] key;
        if (!base_ok[b][c]) return 1'b0;
        kb  = base_key[b][c][9:8];
        key = base_key[b][c][7:0];
        if (kb >= kb_count) return 1'b0;
        if (!key_st[kb][key][0]) return 1'b0;
        if (shot && key_st[kb][key] != 2'd3) return 1'b0;
        for (int m = 1; m <= MODS_DEF; m++)
            if (mod_ok[b][c][m] && !key_st[kb][mod_key[b][c][m]][0]) return 1'b0;
        // reject extra held modifiers that any rule ties to this base key
        for (int b2 = 0; b2 < BUTTONS_DEF; b2++)
            for (int c2 = 0; c2 < COMBOS_DEF; c2++) begin
                if (!base_ok[b2][c2] || base_key[b2][c2] != base_key[b][c]) continue;
                for (int m = 1; m <= MODS_DEF; m++)
                    if (mod_ok[b2][c2][m] && key_st[kb][mod_key[b2][c2][m]][0]
                        && !combo_uses(b, c, mod_key[b2][c2][m])) return 1'b0;
            end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        int n;
        logic hit;
        if (!i_rst_n) begin
            foreach (key_st[a, k]) key_st[a][k] = 2'd0;
            foreach (base_ok[b, c]) base_ok[b][c] = 1'b0;
            foreach (mod_ok[b, c, m]) mod_ok[b][c][m] = 1'b0;
            kb_count = 1;
            o_errors = 0;
            expected_active.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                n = i_cfg_data;
                if (n == 0) n = 1;
                if (n > KEYBOARDS_DEF) n = KEYBOARDS_DEF;
                for (int kb = kb_count; kb < n; kb++)
                    for (int k = 0; k < KEYS_DEF; k++) key_st[kb][k] = 2'd0;
                kb_count = n;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_active.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result beat: expected none got active=%0d",
                                 i_active);
                end else begin
                    hit = expected_active.pop_front();
                    if (hit !== i_active) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("active mismatch: expected %0d got %0d", hit, i_active);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                hit = 1'b0;
                case (i_opcode)
                    OPC_SAMPLE: begin
                        if (i_keyboard < kb_count)
                            key_st[i_keyboard][i_key_index] =
                                {key_st[i_keyboard][i_key_index][0] ^ i_pressed, i_pressed};
                    end
                    OPC_RULE: begin
                        if (i_key_slot == 0) begin
                            base_ok[i_button_id][i_combo_slot]  = i_entry_valid;
                            base_key[i_button_id][i_combo_slot] = {i_keyboard, i_key_index};
                        end else begin
                            mod_ok[i_button_id][i_combo_slot][i_key_slot]  = i_entry_valid;
                            mod_key[i_button_id][i_combo_slot][i_key_slot] = i_key_index;
                        end
                    end
                    OPC_QUERY: begin
                        for (int c = 0; c < COMBOS_DEF; c++)
                            if (chord_on(i_button_id, c, i_oneshot)) hit = 1'b1;
                    end
                    default: foreach (key_st[a, k]) key_st[a][k] = 2'd0;
                endcase
                expected_active.push_back(hit);
            end
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives key samples, rule writes, queries and clears into the key chord
// matcher across keyboard counts, with random idle and stall on both sides.
// ----------------------------------------------------------------------------

module testbench;
    import kcm_pkg::*;

    localparam int WATCHDOG = 200000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [OPC_W-1:0] opcode = OPC_SAMPLE;
    logic [KB_W-1:0]  keyboard = '0;
    logic [KEY_W-1:0] key_index = '0;
    logic             pressed = 1'b0;
    logic [BTN_W-1:0] button_id = '0;
    logic [CS_W-1:0]  combo_slot = '0;
    logic [KS_W-1:0]  key_slot = '0;
    logic             entry_valid = 1'b0;
    logic             oneshot = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b1;
    logic             active;
    int               errors;
    int               pending;
    int               idle_cycles = 0;
    logic             calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    key_chord_matcher_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(opcode), .i_keyboard(keyboard), .i_key_index(key_index),
        .i_pressed(pressed), .i_button_id(button_id), .i_combo_slot(combo_slot),
        .i_key_slot(key_slot), .i_entry_valid(entry_valid), .i_oneshot(oneshot),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_active(active)
    );

    kcm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_opcode(opcode), .i_keyboard(keyboard), .i_key_index(key_index),
        .i_pressed(pressed), .i_button_id(button_id), .i_combo_slot(combo_slot),
        .i_key_slot(key_slot), .i_entry_valid(entry_valid), .i_oneshot(oneshot),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_active(active),
        .o_errors(errors), .o_pending(pending)
    );

    // result side: random stall, none while calm
    always @(negedge i_clk)
        out_stall <= i_rst_n && !calm && ($urandom_range(99) < 38);

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // valid stays up between beats unless an idle cycle is drawn
    task automatic send_beat(input logic [OPC_W-1:0] op, input logic [KB_W-1:0] kb,
                             input logic [KEY_W-1:0] key, input logic prs,
                             input logic [BTN_W-1:0] btn, input logic [CS_W-1:0] cs,
                             input logic [KS_W-1:0] ks, input logic ev, input logic shot);
        while (!calm && $urandom_range(99) < 38) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        opcode <= op; keyboard <= kb; key_index <= key; pressed <= prs;
        button_id <= btn; combo_slot <= cs; key_slot <= ks;
        entry_valid <= ev; oneshot <= shot; in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_keyboards(input logic [CFG_W-1:0] n);
        drain();
        cfg_data <= n; cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic key(input int kb, input int k, input logic prs);
        send_beat(OPC_SAMPLE, KB_W'(kb), KEY_W'(k), prs, BTN_W'($urandom), CS_W'($urandom),
                  KS_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic rule(input int btn, input int cs, input int ks, input int kb,
                        input int k, input logic ev);
        send_beat(OPC_RULE, KB_W'(kb), KEY_W'(k), 1'($urandom), BTN_W'(btn), CS_W'(cs),
                  KS_W'(ks), ev, 1'($urandom));
    endtask

    task automatic query(input int btn, input logic shot);
        send_beat(OPC_QUERY, KB_W'($urandom), KEY_W'($urandom), 1'($urandom), BTN_W'(btn),
                  CS_W'($urandom), KS_W'($urandom), 1'($urandom), shot);
    endtask

    initial begin
        int kb, base, btn, cs;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: chord with a repeated modifier and a foreign modifier
        set_keyboards(3'd0);
        rule(0, 0, 0, 0, 8'h00, 1'b1);
        rule(0, 0, 1, 0, 8'hFF, 1'b1);
        rule(0, 0, 2, 0, 8'hFF, 1'b1);
        rule(15, 3, 0, 0, 8'h00, 1'b1);
        rule(15, 3, 3, 0, 8'h80, 1'b1);
        key(0, 8'hFF, 1'b1);
        key(0, 8'h00, 1'b1);
        query(0, 1'b1);
        query(0, 1'b0);
        key(0, 8'h00, 1'b1);
        query(0, 1'b1);
        query(0, 1'b0);
        key(0, 8'h80, 1'b1);
        query(0, 1'b0);
        query(15, 1'b0);
        key(3, 8'h10, 1'b1);
        rule(1, 0, 0, 3, 8'h10, 1'b1);
        query(1, 1'b0);
        send_beat(OPC_CLEAR, '0, '0, 1'b0, '0, '0, '0, 1'b0, 1'b0);
        query(0, 1'b0);
        rule(0, 0, 0, 0, 0, 1'b0);
        query(0, 1'b0);
        set_keyboards(3'd7);
        key(3, 8'h10, 1'b1);
        query(1, 1'b1);

        // random frames; restrict keys so chords actually form
        for (int i = 0; i < 1000; i++) begin
            if (i % 200 == 100) set_keyboards(CFG_W'($urandom_range(7)));
            if (i == 300) begin
                drain();
                calm = 1'b1;
            end
            if (i == 450) calm = 1'b0;
            kb = $urandom_range(3);
            base = $urandom_range(3);
            btn = $urandom_range(15);
            cs = $urandom_range(3);
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6: key(kb, (i % 25 == 0) ? $urandom : $urandom_range(7),
                                          1'($urandom));
                7, 8, 9:   rule(btn, cs, $urandom_range(3), kb,
                                (i % 25 == 1) ? $urandom : $urandom_range(7),
                                $urandom_range(3) != 0);
                10, 11, 12, 13, 14, 15, 16, 17: query(btn, 1'($urandom));
                18: if ($urandom_range(3) == 0)
                        send_beat(OPC_CLEAR, KB_W'($urandom), KEY_W'($urandom), 1'($urandom),
                                  BTN_W'($urandom), CS_W'($urandom), KS_W'($urandom),
                                  1'($urandom), 1'($urandom));
                    else query(btn, 1'($urandom));
                default: key(kb, $urandom_range(7), 1'($urandom));
            endcase
        end
        drain();
        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

endmodule
